### rtl/qosm_pkg.sv
package qosm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int TABLE_DEPTH_DEF = 16384;

	localparam int CMD_BITS   = 2;
	localparam int LEN_BITS   = 15;
	localparam int GAIN_BITS  = 7;
	localparam int GAP_BITS   = 16;
	localparam int QUEUE_BITS = 4;
	localparam int INDEX_BITS = 14;
	localparam int CLIP_BITS  = 2;

	localparam int CFG_ADDR_BITS = 4;
	localparam int CFG_DATA_BITS = 32;
	localparam int REG_IDX_LSB   = 2;

	localparam logic [LEN_BITS-1:0]   POS_IDLE     = 15'd16384;
	localparam logic [LEN_BITS-1:0]   CHIME_LEN_RST = 15'd0;
	localparam logic [GAIN_BITS-1:0]  GAIN_RST     = 7'd100;
	localparam logic [GAP_BITS-1:0]   GAP_RST      = 16'd4800;
	localparam logic [QUEUE_BITS-1:0] MAXQ_RST     = 4'd8;

	// floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 2**30
	localparam int                    RECIP_SHIFT = 32;
	localparam int                    RECIP_BITS  = 26;
	localparam logic [RECIP_BITS-1:0] RECIP       = 26'd42949673;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_MIX     = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_WRITE   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CHIME_LENGTH = 2'd0,
		REG_GAIN_PERCENT = 2'd1,
		REG_GAP_FRAMES   = 2'd2,
		REG_MAX_QUEUED   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic active;
		logic last;
	} tag_t;

	typedef struct packed {
		logic valid;
		logic use_sample;
		tag_t tag;
	} iss_t;

	typedef struct packed {
		logic                     sel;
		logic                     enable;
		logic                     write;
		logic [CFG_ADDR_BITS-1:0] addr;
		logic [CFG_DATA_BITS-1:0] wdata;
	} apb_req_t;

endpackage

### rtl/qosm_if.sv
interface qosm_in_if #(
	parameter int SAMPLE_BITS = qosm_pkg::SAMPLE_BITS_DEF
) ();
	logic                                 valid;
	logic                                 ready;
	logic [qosm_pkg::CMD_BITS-1:0]        command;
	logic signed [SAMPLE_BITS-1:0]        left_in;
	logic signed [SAMPLE_BITS-1:0]        right_in;
	logic                                 last_in_buffer;
	logic [qosm_pkg::INDEX_BITS-1:0]      table_index;
	logic signed [SAMPLE_BITS-1:0]        table_value;

	modport source (
		output valid, command, left_in, right_in, last_in_buffer, table_index, table_value,
		input  ready
	);
	modport sink (
		input  valid, command, left_in, right_in, last_in_buffer, table_index, table_value,
		output ready
	);
endinterface

interface qosm_out_if #(
	parameter int SAMPLE_BITS = qosm_pkg::SAMPLE_BITS_DEF
) ();
	logic                             valid;
	logic                             ready;
	logic signed [SAMPLE_BITS-1:0]    left_out;
	logic signed [SAMPLE_BITS-1:0]    right_out;
	logic [qosm_pkg::CLIP_BITS-1:0]   clipped_count;
	logic                             sound_active;
	logic                             last_out;

	modport source (
		output valid, left_out, right_out, clipped_count, sound_active, last_out,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out, clipped_count, sound_active, last_out,
		output ready
	);
endinterface

### rtl/qosm_ram.sv
module qosm_ram #(
	parameter  int WIDTH = 16,
	parameter  int DEPTH = 16384,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/qosm_ctrl.sv
module qosm_ctrl #(
	parameter  int TABLE_DEPTH = 16384,
	parameter  int SAMPLE_BITS = 16,
	localparam int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qosm_pkg::apb_req_t                    apb,
	output logic [qosm_pkg::CFG_DATA_BITS-1:0]    prdata,
	input  logic                                  fire,
	input  logic [qosm_pkg::CMD_BITS-1:0]         command,
	input  logic [qosm_pkg::INDEX_BITS-1:0]       table_index,
	input  logic signed [SAMPLE_BITS-1:0]         table_value,
	input  logic                                  last,
	output logic [qosm_pkg::GAIN_BITS-1:0]        gain,
	output qosm_pkg::iss_t                        iss,
	output logic                                  ram_we,
	output logic [AW-1:0]                         ram_waddr,
	output logic [SAMPLE_BITS-1:0]                ram_wdata,
	output logic                                  ram_re,
	output logic [AW-1:0]                         ram_raddr
);
	import qosm_pkg::*;

	logic [LEN_BITS-1:0]   chime_len_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [GAP_BITS-1:0]   gap_frames_q;
	logic [QUEUE_BITS-1:0] max_queued_q;

	logic [LEN_BITS-1:0]   pos_q, pos_n;
	logic [QUEUE_BITS-1:0] queued_q, queued_n;
	logic [GAP_BITS-1:0]   gap_q, gap_n;

	logic        cfg_wr;
	reg_idx_t    reg_idx;
	logic        active;
	logic        use_s, rd_zero, pos_in_range, idx_in_range;
	logic [31:0] pos_ext, idx_ext;
	logic [LEN_BITS-1:0] pos_inc;

	assign cfg_wr  = apb.sel & apb.enable & apb.write;
	assign reg_idx = reg_idx_t'(apb.addr[CFG_ADDR_BITS-1:REG_IDX_LSB]);

	always_comb begin
		case (reg_idx)
			REG_CHIME_LENGTH: prdata = CFG_DATA_BITS'(chime_len_q);
			REG_GAIN_PERCENT: prdata = CFG_DATA_BITS'(gain_q);
			REG_GAP_FRAMES:   prdata = CFG_DATA_BITS'(gap_frames_q);
			REG_MAX_QUEUED:   prdata = CFG_DATA_BITS'(max_queued_q);
			default:          prdata = '0;
		endcase
	end

	assign active       = (pos_q < chime_len_q) || (queued_q != '0);
	assign pos_inc      = pos_q + LEN_BITS'(1);
	assign pos_ext      = 32'(pos_q);
	assign idx_ext      = 32'(table_index);
	assign pos_in_range = pos_ext < 32'(TABLE_DEPTH);
	assign idx_in_range = idx_ext < 32'(TABLE_DEPTH);

	always_comb begin
		pos_n    = pos_q;
		queued_n = queued_q;
		gap_n    = gap_q;
		use_s    = 1'b0;
		rd_zero  = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		if (fire) begin
			case (cmd_t'(command))
				CMD_TRIGGER: begin
					if (chime_len_q != '0) begin
						if (active) begin
							if (queued_q < max_queued_q) begin
								queued_n = queued_q + QUEUE_BITS'(1);
							end
						end else begin
							pos_n = '0;
							gap_n = '0;
						end
					end
				end
				CMD_WRITE: begin
					ram_we = idx_in_range;
				end
				CMD_MIX: begin
					ram_re = 1'b1;
					if (active && gain_q != '0) begin
						if (pos_q < chime_len_q) begin
							use_s = 1'b1;
							pos_n = pos_inc;
							if (pos_inc == chime_len_q && queued_q != '0) begin
								gap_n = gap_frames_q;
							end
						end else if (queued_q != '0) begin
							if (gap_q != '0) begin
								gap_n = gap_q - GAP_BITS'(1);
							end else begin
								queued_n = queued_q - QUEUE_BITS'(1);
								use_s    = 1'b1;
								rd_zero  = 1'b1;
								pos_n    = LEN_BITS'(1);
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_waddr = idx_ext[AW-1:0];
	assign ram_wdata = table_value;
	assign ram_raddr = rd_zero ? '0 : pos_ext[AW-1:0];

	assign iss.valid      = fire && (cmd_t'(command) == CMD_MIX);
	assign iss.use_sample = use_s && (rd_zero || pos_in_range);
	assign iss.tag.active = (pos_n < chime_len_q) || (queued_n != '0);
	assign iss.tag.last   = last;

	assign gain = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chime_len_q  <= CHIME_LEN_RST;
			gain_q       <= GAIN_RST;
			gap_frames_q <= GAP_RST;
			max_queued_q <= MAXQ_RST;
			pos_q        <= POS_IDLE;
			queued_q     <= '0;
			gap_q        <= '0;
		end else begin
			pos_q    <= pos_n;
			queued_q <= queued_n;
			gap_q    <= gap_n;
			if (cfg_wr) begin
				case (reg_idx)
					REG_CHIME_LENGTH: chime_len_q  <= apb.wdata[LEN_BITS-1:0];
					REG_GAIN_PERCENT: gain_q       <= apb.wdata[GAIN_BITS-1:0];
					REG_GAP_FRAMES:   gap_frames_q <= apb.wdata[GAP_BITS-1:0];
					REG_MAX_QUEUED:   max_queued_q <= apb.wdata[QUEUE_BITS-1:0];
					default: begin
					end
				endcase
			end
		end
	end
endmodule

### rtl/qosm_mix.sv
module qosm_mix #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qosm_pkg::iss_t                    iss,
	input  logic signed [SAMPLE_BITS-1:0]     left_in,
	input  logic signed [SAMPLE_BITS-1:0]     right_in,
	input  logic [SAMPLE_BITS-1:0]            rdata,
	input  logic [qosm_pkg::GAIN_BITS-1:0]    gain,
	output logic                              take,
	qosm_out_if.source                        mixed
);
	import qosm_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int PW     = SB + GAIN_BITS + 1;
	localparam int MW     = SB + GAIN_BITS;
	localparam int QMW    = MW + RECIP_BITS;
	localparam int SW     = SB + 2;
	localparam int SMAX_I = (1 << (SB - 1)) - 1;
	localparam logic signed [SW-1:0] SMAX = SW'(SMAX_I);
	localparam logic signed [SW-1:0] SMIN = SW'(-SMAX_I - 1);

	logic mv1, mv2, mv3;

	logic              v_s1, use_s1;
	tag_t              tag_s1;
	logic signed [SB-1:0] l_s1, r_s1;

	logic              v_s2;
	tag_t              tag_s2;
	logic signed [SB-1:0] l_s2, r_s2;
	logic signed [PW-1:0] prod_s2;

	logic              v_s3, neg_s3;
	tag_t              tag_s3;
	logic signed [SB-1:0] l_s3, r_s3;
	logic [SB-1:0]     q_s3;

	logic                  out_valid_q, active_q, last_q;
	logic signed [SB-1:0]  left_q, right_q;
	logic [CLIP_BITS-1:0]  clip_q;

	logic signed [SB-1:0] c1;
	logic signed [PW-1:0] prod1;
	logic [PW-1:0]        absv;
	logic [QMW-1:0]       qmul;
	logic signed [SB:0]   c3;
	logic signed [SW-1:0] sum_l, sum_r;
	logic signed [SB-1:0] sat_l, sat_r;
	logic                 clip_l, clip_r;

	assign mv3  = !out_valid_q || mixed.ready;
	assign mv2  = !v_s3 || mv3;
	assign mv1  = !v_s2 || mv2;
	assign take = !v_s1 || mv1;

	assign c1    = use_s1 ? signed'(rdata) : '0;
	assign prod1 = c1 * signed'({1'b0, gain});

	assign absv = prod_s2[PW-1] ? PW'(-prod_s2) : PW'(prod_s2);
	assign qmul = QMW'(absv[MW-1:0]) * QMW'(RECIP);

	assign c3    = neg_s3 ? -signed'({1'b0, q_s3}) : signed'({1'b0, q_s3});
	assign sum_l = SW'(l_s3) + SW'(c3);
	assign sum_r = SW'(r_s3) + SW'(c3);

	always_comb begin
		clip_l = 1'b0;
		clip_r = 1'b0;
		sat_l  = sum_l[SB-1:0];
		sat_r  = sum_r[SB-1:0];
		if (sum_l > SMAX) begin
			sat_l  = SMAX[SB-1:0];
			clip_l = 1'b1;
		end else if (sum_l < SMIN) begin
			sat_l  = SMIN[SB-1:0];
			clip_l = 1'b1;
		end
		if (sum_r > SMAX) begin
			sat_r  = SMAX[SB-1:0];
			clip_r = 1'b1;
		end else if (sum_r < SMIN) begin
			sat_r  = SMIN[SB-1:0];
			clip_r = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= iss.valid;
			end
			if (mv1) begin
				v_s2 <= v_s1;
			end
			if (mv2) begin
				v_s3 <= v_s2;
			end
			if (mv3) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			use_s1 <= iss.use_sample;
			tag_s1 <= iss.tag;
			l_s1   <= left_in;
			r_s1   <= right_in;
		end
		if (mv1) begin
			tag_s2  <= tag_s1;
			l_s2    <= l_s1;
			r_s2    <= r_s1;
			prod_s2 <= prod1;
		end
		if (mv2) begin
			tag_s3 <= tag_s2;
			l_s3   <= l_s2;
			r_s3   <= r_s2;
			neg_s3 <= prod_s2[PW-1];
			q_s3   <= qmul[RECIP_SHIFT +: SB];
		end
		if (mv3) begin
			left_q   <= sat_l;
			right_q  <= sat_r;
			clip_q   <= CLIP_BITS'(clip_l) + CLIP_BITS'(clip_r);
			active_q <= tag_s3.active;
			last_q   <= tag_s3.last;
		end
	end

	assign mixed.valid         = out_valid_q;
	assign mixed.left_out      = left_q;
	assign mixed.right_out     = right_q;
	assign mixed.clipped_count = clip_q;
	assign mixed.sound_active  = active_q;
	assign mixed.last_out      = last_q;
endmodule

### rtl/queued_oneshot_sample_mixer.sv
// Queued one-shot sample mixer.
// stream: input items, valid/ready. command selects mix frame, trigger
//   playback or sample table write. Every item is taken while
//   stream.ready is high; only mix items give a result.
// mixed: one result per mix item, valid/ready, in order of transfer.
// APB port: chime_length, gain_percent, gap_frames, max_queued at byte
//   addresses 0, 4, 8, 12; pready is tied high; write while idle.
// Pipeline: the table read is registered at the transfer edge, then gain
//   multiply, reciprocal multiply for /100 and saturating add are each
//   registered.
// Throughput: one item per cycle while not stalled; playback state is
//   updated in the accept cycle, so a trigger or table write may directly precede a mix.
// Stall: with mixed.ready low the stages fill up; stream.ready drops
//   only when all four stages hold results.
// Reset: registers take their defaults, playback goes idle and the
//   pipeline empties. The sample table is not cleared; load it before use.
module queued_oneshot_sample_mixer #(
	parameter  int TABLE_DEPTH = qosm_pkg::TABLE_DEPTH_DEF,
	parameter  int SAMPLE_BITS = qosm_pkg::SAMPLE_BITS_DEF,
	localparam int AW          = $clog2(TABLE_DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	qosm_in_if.sink                              stream,
	qosm_out_if.source                           mixed,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [qosm_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [qosm_pkg::CFG_DATA_BITS-1:0]   pwdata,
	output logic [qosm_pkg::CFG_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import qosm_pkg::*;

	apb_req_t               apb;
	iss_t                   iss;
	logic                   fire, take;
	logic [GAIN_BITS-1:0]   gain;
	logic                   ram_we, ram_re;
	logic [AW-1:0]          ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_wdata, ram_rdata;

	assign apb.sel    = psel;
	assign apb.enable = penable;
	assign apb.write  = pwrite;
	assign apb.addr   = paddr;
	assign apb.wdata  = pwdata;
	assign pready     = 1'b1;

	assign stream.ready = take;
	assign fire         = stream.valid & take;

	qosm_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.apb         (apb),
		.prdata      (prdata),
		.fire        (fire),
		.command     (stream.command),
		.table_index (stream.table_index),
		.table_value (stream.table_value),
		.last        (stream.last_in_buffer),
		.gain        (gain),
		.iss         (iss),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr)
	);

	qosm_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	qosm_mix #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.left_in  (stream.left_in),
		.right_in (stream.right_in),
		.rdata    (ram_rdata),
		.gain     (gain),
		.take     (take),
		.mixed    (mixed)
	);
endmodule

### tb/tb_queued_oneshot_sample_mixer.sv
`timescale 1ns / 100ps

module tb_queued_oneshot_sample_mixer;
	import qosm_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	localparam int HOLD_CYCLES   = 40;
	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SAT_HI        = 32767;
	localparam int SAT_LO        = -32768;

	typedef struct {
		logic [CMD_BITS-1:0]   command;
		logic signed [15:0]    left;
		logic signed [15:0]    right;
		logic                  last;
		logic [INDEX_BITS-1:0] index;
		logic signed [15:0]    value;
	} stream_item_t;

	typedef struct packed {
		logic [15:0]          left;
		logic [15:0]          right;
		logic [CLIP_BITS-1:0] clips;
		logic                 active;
		logic                 last;
	} mix_frame_t;

	class frame_mix_tracker;
		logic [LEN_BITS-1:0]   chime_len;
		logic [GAIN_BITS-1:0]  gain;
		logic [GAP_BITS-1:0]   gap_len;
		logic [QUEUE_BITS-1:0] max_q;
		logic [LEN_BITS-1:0]   position;
		logic [QUEUE_BITS-1:0] queued;
		logic [GAP_BITS-1:0]   gap_left;
		logic signed [15:0]    chime [TABLE_DEPTH_DEF];
		bit                    loaded [TABLE_DEPTH_DEF];
		mix_frame_t            frames_due [$];
		int mismatches, frames_checked, clipped_frames, sounding_frames;

		function new();
			position = POS_IDLE;
			queued = '0;
			gap_left = '0;
			chime_len = CHIME_LEN_RST;
			gain = GAIN_RST;
			gap_len = GAP_RST;
			max_q = MAXQ_RST;
		endfunction

		function void set_reg(reg_idx_t r, logic [31:0] v);
			case (r)
			REG_CHIME_LENGTH: chime_len = v[LEN_BITS-1:0];
			REG_GAIN_PERCENT: gain = v[GAIN_BITS-1:0];
			REG_GAP_FRAMES:   gap_len = v[GAP_BITS-1:0];
			REG_MAX_QUEUED:   max_q = v[QUEUE_BITS-1:0];
			default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(reg_idx_t r);
			case (r)
			REG_CHIME_LENGTH: return 32'(chime_len);
			REG_GAIN_PERCENT: return 32'(gain);
			REG_GAP_FRAMES:   return 32'(gap_len);
			default:          return 32'(max_q);
			endcase
		endfunction

		function bit sounding();
			return position < chime_len || queued != 0;
		endfunction

		// table entry the next mix frame will fetch, if any
		function bit next_read(output int idx);
			idx = 0;
			if (!sounding() || gain == 0)
				return 0;
			if (position < chime_len) begin
				idx = position;
				return 1;
			end
			return queued != 0 && gap_left == 0;
		endfunction

		function int clamp(int v, inout logic [CLIP_BITS-1:0] clips);
			if (v > SAT_HI) begin
				clips++;
				return SAT_HI;
			end
			if (v < SAT_LO) begin
				clips++;
				return SAT_LO;
			end
			return v;
		endfunction

		function mix_frame_t mix_frame(stream_item_t it);
			int l, r, c;
			logic [CLIP_BITS-1:0] clips;
			mix_frame_t f;
			l = it.left;
			r = it.right;
			c = 0;
			clips = '0;
			if (sounding() && gain != 0) begin
				if (position < chime_len) begin
					c = chime[position];
					position++;
					if (position == chime_len && queued != 0)
						gap_left = gap_len;
				end else if (queued != 0) begin
					if (gap_left != 0) begin
						gap_left--;
					end else begin
						queued--;
						c = chime[0];
						position = 1;
					end
				end
				c = (c * int'(gain)) / 100;
				l = clamp(l + c, clips);
				r = clamp(r + c, clips);
			end
			f.left = l[15:0];
			f.right = r[15:0];
			f.clips = clips;
			f.active = sounding();
			f.last = it.last;
			if (clips != 0)
				clipped_frames++;
			if (f.active)
				sounding_frames++;
			return f;
		endfunction

		function void note_transfer(stream_item_t it);
			case (it.command)
			CMD_MIX: frames_due.push_back(mix_frame(it));
			CMD_TRIGGER: begin
				if (chime_len != 0) begin
					if (sounding()) begin
						if (queued < max_q)
							queued++;
					end else begin
						position = '0;
						gap_left = '0;
					end
				end
			end
			CMD_WRITE: begin
				chime[it.index] = it.value;
				loaded[it.index] = 1'b1;
			end
			default: ;
			endcase
		endfunction

		function void note_mismatch(string s);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s", s);
		endfunction

		function void check_frame(mix_frame_t got);
			mix_frame_t want;
			frames_checked++;
			if (frames_due.size() == 0) begin
				note_mismatch($sformatf("frame with none due: L=%0d R=%0d",
					$signed(got.left), $signed(got.right)));
				return;
			end
			want = frames_due.pop_front();
			if (got !== want)
				note_mismatch($sformatf(
					"frame %0d: want L=%0d R=%0d clip=%0d act=%0b last=%0b, got L=%0d R=%0d clip=%0d act=%0b last=%0b",
					frames_checked, $signed(want.left), $signed(want.right), want.clips,
					want.active, want.last, $signed(got.left), $signed(got.right),
					got.clips, got.active, got.last));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	qosm_in_if  stream ();
	qosm_out_if mixed ();

	queued_oneshot_sample_mixer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.mixed   (mixed),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	frame_mix_tracker sb = new();
	int transfers, settings, cycles, holds_asked, holds_done, burst_left;
	bit steady;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin : frame_monitor
		mix_frame_t got;
		if (arst_n && mixed.valid && mixed.ready) begin
			got.left = mixed.left_out;
			got.right = mixed.right_out;
			got.clips = mixed.clipped_count;
			got.active = mixed.sound_active;
			got.last = mixed.last_out;
			sb.check_frame(got);
		end
	end

	// receiver stall patterns; a requested hold keeps ready low for HOLD_CYCLES
	initial begin : rx_pacing
		int mode, span, held;
		mode = 0;
		span = 0;
		held = 0;
		mixed.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done < holds_asked) begin
				mixed.ready <= 1'b0;
				held++;
				if (held == HOLD_CYCLES) begin
					held = 0;
					holds_done++;
				end
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(10, 150);
				end
				span--;
				case (mode)
				0:       mixed.ready <= 1'b1;
				1:       mixed.ready <= ($urandom_range(0, 9) < 7);
				2:       mixed.ready <= (span % 3 == 0);
				default: mixed.ready <= ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	function automatic logic signed [15:0] sample16();
		case ($urandom_range(0, 9))
		0:       return 16'sh7fff;
		1:       return 16'sh8000;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic stream_item_t make_item(logic [CMD_BITS-1:0] cmd,
		logic signed [15:0] l, logic signed [15:0] r, logic last,
		logic [INDEX_BITS-1:0] idx, logic signed [15:0] v);
		stream_item_t it;
		it.command = cmd;
		it.left = l;
		it.right = r;
		it.last = last;
		it.index = idx;
		it.value = v;
		return it;
	endfunction

	function automatic stream_item_t random_item();
		stream_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.command = pick < 70 ? CMD_MIX : pick < 82 ? CMD_TRIGGER :
			pick < 97 ? CMD_WRITE : CMD_UNUSED;
		it.left = sample16();
		it.right = sample16();
		it.last = 1'($urandom);
		it.index = $urandom_range(0, 1) ? 14'($urandom) : 14'($urandom_range(0, 63));
		it.value = sample16();
		return it;
	endfunction

	task automatic send(stream_item_t it);
		stream.valid <= 1'b1;
		stream.command <= it.command;
		stream.left_in <= it.left;
		stream.right_in <= it.right;
		stream.last_in_buffer <= it.last;
		stream.table_index <= it.index;
		stream.table_value <= it.value;
		do @(posedge clk); while (!stream.ready);
		sb.note_transfer(it);
		transfers++;
	endtask

	task automatic pace();
		int n;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 24);
		n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		if (n > 0) begin
			stream.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// never let a mix frame fetch a table entry that was not loaded
	task automatic feed(stream_item_t it);
		int idx;
		if (it.command == CMD_MIX && sb.next_read(idx) && !sb.loaded[idx]) begin
			pace();
			send(make_item(CMD_WRITE, 0, 0, 0, idx[INDEX_BITS-1:0], sample16()));
		end
		pace();
		send(it);
	endtask

	task automatic settle();
		stream.valid <= 1'b0;
		while (sb.frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_reg(reg_idx_t r, logic [31:0] v);
		logic [31:0] rd;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'(r) << REG_IDX_LSB;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(r, v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== sb.reg_value(r))
			sb.note_mismatch($sformatf("%s reads %0d, want %0d", r.name(), rd,
				sb.reg_value(r)));
	endtask

	task automatic retune(int len, int gain, int gap, int maxq);
		settle();
		program_reg(REG_CHIME_LENGTH, len);
		program_reg(REG_GAIN_PERCENT, gain);
		program_reg(REG_GAP_FRAMES, gap);
		program_reg(REG_MAX_QUEUED, maxq);
		settings++;
	endtask

	task automatic run_phase(int len, int gain, int gap, int maxq, int count, bit squeeze);
		stream_item_t it;
		int forced;
		retune(len, gain, gap, maxq);
		steady = ($urandom_range(0, 3) == 0);
		burst_left = 0;
		forced = 0;
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == count / 2) begin
				holds_asked++;
				burst_left = 48;
				forced = 48;
			end
			it = random_item();
			if (forced > 0) begin
				it.command = CMD_MIX;
				forced--;
			end
			feed(it);
		end
	endtask

	initial begin
		stream_item_t it;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		stream.valid <= 1'b0;
		stream.command <= CMD_MIX;
		stream.left_in <= '0;
		stream.right_in <= '0;
		stream.last_in_buffer <= 1'b0;
		stream.table_index <= '0;
		stream.table_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty sound, so triggers do nothing and frames pass
		feed(make_item(CMD_TRIGGER, 0, 0, 0, 0, 0));
		feed(make_item(CMD_MIX, 16'sh7fff, 16'sh8000, 1, 0, 0));
		feed(make_item(CMD_UNUSED, 0, 0, 0, 0, 0));
		feed(make_item(CMD_WRITE, 0, 0, 0, 14'h3fff, 16'sh8000));

		// short sound, queue of two with a fourth trigger dropped
		retune(4, 100, 2, 2);
		feed(make_item(CMD_WRITE, 0, 0, 0, 14'd0, 16'sh7fff));
		feed(make_item(CMD_WRITE, 0, 0, 0, 14'd1, 16'sh8000));
		feed(make_item(CMD_WRITE, 0, 0, 0, 14'd2, 16'sh4000));
		feed(make_item(CMD_WRITE, 0, 0, 0, 14'd3, 16'shffff));
		repeat (4) feed(make_item(CMD_TRIGGER, 0, 0, 0, 0, 0));
		feed(make_item(CMD_MIX, 16'sh7fff, 16'sh0000, 0, 0, 0));
		feed(make_item(CMD_MIX, 16'sh8000, 16'sh8000, 1, 0, 0));
		for (int k = 0; k < 8; k++)
			feed(make_item(CMD_MIX, 16'(k * 4000), -16'(k * 4000), k[0], 0, 0));

		run_phase(16, 100, 3, 3, 120, 0);
		run_phase(1, 127, 0, 15, 110, 0);
		run_phase(40, 0, 5, 4, 80, 0);
		run_phase(8, 1, 10, 0, 90, 0);
		run_phase(16384, 75, 65535, 0, 90, 0);

		// long sound with playbacks queued, then cut it short mid-play
		retune(16384, 100, 7, 3);
		repeat (3) feed(make_item(CMD_TRIGGER, 0, 0, 0, 0, 0));
		for (int k = 0; k < 20; k++) begin
			it = random_item();
			it.command = CMD_MIX;
			feed(it);
		end
		run_phase(5, 100, 7, 3, 100, 1);

		run_phase(100, 50, 20, 15, 150, 1);
		run_phase(3, 100, 1, 1, 120, 0);
		run_phase(0, 100, 2, 5, 80, 0);
		run_phase(12, 127, 0, 15, 150, 1);
		run_phase(30, 99, 4, 8, 140, 0);
		run_phase(20, 100, 0, 15, 150, 0);
		run_phase(6, 60, 2, 2, 120, 0);

		settle();
		$display("Covered %0d transfers over %0d register settings: %0d frames checked,",
			transfers, settings, sb.frames_checked);
		$display("%0d with clipping, %0d with sound active, %0d long receiver holds",
			sb.clipped_frames, sb.sounding_frames, holds_done);
		if (sb.mismatches == 0 && sb.frames_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/qosm_pkg.sv
rtl/qosm_if.sv
rtl/qosm_ram.sv
rtl/qosm_ctrl.sv
rtl/qosm_mix.sv
rtl/queued_oneshot_sample_mixer.sv
tb/tb_queued_oneshot_sample_mixer.sv
